@@ hw/rtl/fdts_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow delay tail statistics package
// Shared widths, register map, reset values, state codes and control types.
// ----------------------------------------------------------------------------
package fdts_pkg;

  // Default sizing of the sample chain.
  localparam int MAX_SAMPLES_DEF = 512;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register widths.
  localparam int WLEN_W = 10;
  localparam int RANK_W = 9;

  // Configuration register reset values.
  localparam logic [WLEN_W-1:0] WLEN_RST  = 10'd500;
  localparam logic [RANK_W-1:0] LRANK_RST = 9'd450;
  localparam logic [RANK_W-1:0] HRANK_RST = 9'd495;

  // APB register map (word index taken from the address).
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_LOW_RANK      = 2'd1;
  localparam logic [1:0] REG_HIGH_RANK     = 2'd2;

  // Result field layout on the output tdata, lowest bits first.
  localparam int OUT_CNT_W    = 10;
  localparam int FIELD_W      = 16;
  localparam int OUT_CNT_LSB  = 0;
  localparam int OUT_MEAN_LSB = OUT_CNT_LSB + OUT_CNT_W;
  localparam int OUT_MAX_LSB  = OUT_MEAN_LSB + FIELD_W;
  localparam int OUT_LOW_LSB  = OUT_MAX_LSB + FIELD_W;
  localparam int OUT_HIGH_LSB = OUT_LOW_LSB + FIELD_W;
  localparam int OUT_FIELDS_W = OUT_HIGH_LSB + FIELD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // Per-cycle command broadcast to every cell of the sorting chain.
  typedef struct packed {
    logic ins;    // insert the broadcast sample in order
    logic shift;  // move every entry one cell toward the head
    logic clr;    // mark every cell empty
  } cell_ctl_t;

endpackage

@@ hw/rtl/fdts_cell.sv @@
// ----------------------------------------------------------------------------
// Sorting chain cell
// Holds one sample of the ascending window and trades it with its neighbors.
// ----------------------------------------------------------------------------
module fdts_cell #(
  parameter int SAMPLE_BITS = fdts_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fdts_pkg::cell_ctl_t    ctl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] prev_data,
  input  logic                   prev_occ,
  input  logic                   prev_gt,
  input  logic [SAMPLE_BITS-1:0] next_data,
  output logic [SAMPLE_BITS-1:0] data,
  output logic                   occ,
  output logic                   gt
);

  logic [SAMPLE_BITS-1:0] data_r;
  logic [SAMPLE_BITS-1:0] data_nxt;
  logic                   occ_r;
  logic                   occ_nxt;

  // An occupied cell above the new sample must move up by one place.
  assign gt = occ_r && (data_r > sample);

  // Insert: take the lower neighbor's entry if it moves up, else take the
  // sample when this is the first cell that is empty or above it.
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (ctl.ins) begin
      if (prev_gt) begin
        data_nxt = prev_data;
      end else if (prev_occ && (!occ_r || gt)) begin
        data_nxt = sample;
      end
      occ_nxt = occ_r | prev_occ;
    end else if (ctl.shift) begin
      data_nxt = next_data;
    end
    if (ctl.clr) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign occ  = occ_r;

endmodule

@@ hw/rtl/fdts_div.sv @@
// ----------------------------------------------------------------------------
// Window mean divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdts_div #(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Bring down the next dividend bit and try one subtraction.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(DIVIDEND_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? DIVISOR_W'(trial - {1'b0, dvs_r}) : DIVISOR_W'(trial);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/flow_delay_tail_stats_top.sv @@
// ----------------------------------------------------------------------------
// Flow delay tail statistics
// Collects a window of delay samples and reports count, mean, maximum and
// two tail quantiles of the window.
//
//   Channel  Side    Handshake             Payload
//   in_      slave   tvalid/tready         delay_sample
//   out_     master  tvalid/tready         count, mean, max, low/high quantile
//   cfg_     slave   APB, pready tied high window_length, low_rank, high_rank
//
// Samples that do not close their window stream at one per cycle into the
// insertion chain. The sample that closes a window holds off input while the
// chain is shifted out to the highest needed rank and the divider forms the
// mean, and further while an earlier result still waits on out_tready.
// Reset is synchronous and needs no clearing pass; the chain is empty at once.
// The output register lets new samples in while a result waits on out_tready.
// ----------------------------------------------------------------------------
module flow_delay_tail_stats_top #(
  parameter int MAX_SAMPLES = fdts_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = fdts_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [SAMPLE_BITS-1:0] delay_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] sample_count, [25:10] mean_delay, [41:26] max_delay,
  // [57:42] low_quantile_delay, [73:58] high_quantile_delay
  output logic [fdts_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fdts_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [fdts_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [fdts_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int SUM_W   = SAMPLE_BITS + IDX_W;
  localparam int CMP_W   = (CNT_W > fdts_pkg::WLEN_W) ? CNT_W : fdts_pkg::WLEN_W;
  localparam int FIELD_W = fdts_pkg::FIELD_W;
  localparam int PAD_W   = fdts_pkg::OUT_TDATA_W - fdts_pkg::OUT_FIELDS_W;

  // Configuration registers
  logic [fdts_pkg::WLEN_W-1:0] wlen_r;
  logic [fdts_pkg::RANK_W-1:0] lrank_r;
  logic [fdts_pkg::RANK_W-1:0] hrank_r;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;

  // Window state and result capture
  fdts_pkg::state_t       state_r;
  fdts_pkg::state_t       state_nxt;
  logic [CNT_W-1:0]       seen_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] max_r;
  logic [CNT_W-1:0]       cnt_hold_r;
  logic [SAMPLE_BITS-1:0] max_hold_r;
  logic [IDX_W-1:0]       lo_idx_r;
  logic [IDX_W-1:0]       hi_idx_r;
  logic [IDX_W-1:0]       top_idx_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   rank_done_r;
  logic [SAMPLE_BITS-1:0] lo_q_r;
  logic [SAMPLE_BITS-1:0] hi_q_r;
  logic                   out_valid_r;
  logic [fdts_pkg::OUT_TDATA_W-1:0] out_data_r;

  // Derived per-sample values
  logic [SAMPLE_BITS-1:0] sample;
  logic                   in_xfer;
  logic [CNT_W-1:0]       cnt_after;
  logic [SUM_W-1:0]       sum_after;
  logic [SAMPLE_BITS-1:0] max_after;
  logic [CMP_W-1:0]       wlen_ext;
  logic [CMP_W-1:0]       eff_len;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       lrank_ext;
  logic [CMP_W-1:0]       hrank_ext;
  logic [IDX_W-1:0]       lo_clamp;
  logic [IDX_W-1:0]       hi_clamp;
  logic                   win_done;
  logic                   load_out;

  // Chain and divider
  fdts_pkg::cell_ctl_t    ctl;
  logic [SAMPLE_BITS-1:0] c_data [MAX_SAMPLES];
  logic                   c_occ  [MAX_SAMPLES];
  logic                   c_gt   [MAX_SAMPLES];
  logic                   div_start;
  logic                   div_busy;
  logic [SUM_W-1:0]       div_quo;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= fdts_pkg::WLEN_RST;
      lrank_r <= fdts_pkg::LRANK_RST;
      hrank_r <= fdts_pkg::HRANK_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fdts_pkg::REG_WINDOW_LENGTH: wlen_r  <= cfg_pwdata[fdts_pkg::WLEN_W-1:0];
        fdts_pkg::REG_LOW_RANK:      lrank_r <= cfg_pwdata[fdts_pkg::RANK_W-1:0];
        fdts_pkg::REG_HIGH_RANK:     hrank_r <= cfg_pwdata[fdts_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      fdts_pkg::REG_WINDOW_LENGTH: cfg_prdata = fdts_pkg::CFG_DATA_W'(wlen_r);
      fdts_pkg::REG_LOW_RANK:      cfg_prdata = fdts_pkg::CFG_DATA_W'(lrank_r);
      fdts_pkg::REG_HIGH_RANK:     cfg_prdata = fdts_pkg::CFG_DATA_W'(hrank_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Window bookkeeping for the incoming sample
  // --------------------------------------------------------------------------
  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = (state_r == fdts_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cnt_after = seen_r + 1'b1;
  assign sum_after = sum_r + SUM_W'(sample);
  assign max_after = (sample > max_r) ? sample : max_r;

  // Zero length acts as one; lengths above the chain saturate.
  assign wlen_ext = CMP_W'(wlen_r);
  always_comb begin
    if (wlen_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (wlen_ext > CMP_W'(MAX_SAMPLES)) begin
      eff_len = CMP_W'(MAX_SAMPLES);
    end else begin
      eff_len = wlen_ext;
    end
  end

  assign cnt_ext  = CMP_W'(cnt_after);
  assign win_done = cnt_ext >= eff_len;

  // A rank at or past the window end picks the largest sample.
  assign lrank_ext = CMP_W'(lrank_r);
  assign hrank_ext = CMP_W'(hrank_r);
  assign lo_clamp  = (lrank_ext >= cnt_ext) ? IDX_W'(cnt_ext - 1'b1) : IDX_W'(lrank_ext);
  assign hi_clamp  = (hrank_ext >= cnt_ext) ? IDX_W'(cnt_ext - 1'b1) : IDX_W'(hrank_ext);

  assign div_start = in_xfer && win_done;

  // --------------------------------------------------------------------------
  // Control: next state and chain commands
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    load_out  = 1'b0;
    case (state_r)
      fdts_pkg::ST_IDLE: begin
        ctl.ins = in_xfer;
        if (div_start) begin
          state_nxt = fdts_pkg::ST_DRAIN;
        end
      end
      fdts_pkg::ST_DRAIN: begin
        if (!rank_done_r) begin
          if (idx_r == top_idx_r) begin
            ctl.clr = 1'b1;
          end else begin
            ctl.shift = 1'b1;
          end
        end else if (!div_busy) begin
          state_nxt = fdts_pkg::ST_HOLD;
        end
      end
      fdts_pkg::ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = fdts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fdts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Running count, sum and maximum of the open window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      sum_r  <= '0;
      max_r  <= '0;
    end else if (in_xfer) begin
      if (win_done) begin
        seen_r <= '0;
        sum_r  <= '0;
        max_r  <= '0;
      end else begin
        seen_r <= cnt_after;
        sum_r  <= sum_after;
        max_r  <= max_after;
      end
    end
  end

  // Capture window totals and clamped ranks when a window closes.
  always_ff @(posedge clk) begin
    if (div_start) begin
      cnt_hold_r <= cnt_after;
      max_hold_r <= max_after;
      lo_idx_r   <= lo_clamp;
      hi_idx_r   <= hi_clamp;
      top_idx_r  <= (lo_clamp > hi_clamp) ? lo_clamp : hi_clamp;
    end
  end

  // Drain walk: the head cell shows ascending entries one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_done_r <= 1'b0;
      idx_r       <= '0;
    end else if (div_start) begin
      rank_done_r <= 1'b0;
      idx_r       <= '0;
    end else if (ctl.shift) begin
      idx_r <= idx_r + 1'b1;
    end else if (ctl.clr) begin
      rank_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fdts_pkg::ST_DRAIN && !rank_done_r) begin
      if (idx_r == lo_idx_r) begin
        lo_q_r <= c_data[0];
      end
      if (idx_r == hi_idx_r) begin
        hi_q_r <= c_data[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {{PAD_W{1'b0}},
                     FIELD_W'(hi_q_r),
                     FIELD_W'(lo_q_r),
                     FIELD_W'(max_hold_r),
                     FIELD_W'(div_quo),
                     fdts_pkg::OUT_CNT_W'(cnt_hold_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Insertion chain
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev_data;
    logic                   prev_occ;
    logic                   prev_gt;
    logic [SAMPLE_BITS-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_data = '0;
      assign prev_occ  = 1'b1;
      assign prev_gt   = 1'b0;
    end else begin : g_body
      assign prev_data = c_data[i-1];
      assign prev_occ  = c_occ[i-1];
      assign prev_gt   = c_gt[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_link
      assign next_data = c_data[i+1];
    end

    fdts_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sample    (sample),
      .prev_data (prev_data),
      .prev_occ  (prev_occ),
      .prev_gt   (prev_gt),
      .next_data (next_data),
      .data      (c_data[i]),
      .occ       (c_occ[i]),
      .gt        (c_gt[i])
    );
  end

  // Mean of the closed window.
  fdts_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_after),
    .divisor  (cnt_after),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

@@ hw/rtl/fdts_chk.sv @@
// ----------------------------------------------------------------------------
// Flow delay tail statistics port checker
// Watches the top-level ports for stream and result consistency.
// ----------------------------------------------------------------------------
module fdts_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fdts_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [fdts_pkg::FIELD_W-1:0] mean_f;
  logic [fdts_pkg::FIELD_W-1:0] max_f;
  logic [fdts_pkg::FIELD_W-1:0] low_f;
  logic [fdts_pkg::FIELD_W-1:0] high_f;

  assign mean_f = out_tdata[fdts_pkg::OUT_MEAN_LSB +: fdts_pkg::FIELD_W];
  assign max_f  = out_tdata[fdts_pkg::OUT_MAX_LSB  +: fdts_pkg::FIELD_W];
  assign low_f  = out_tdata[fdts_pkg::OUT_LOW_LSB  +: fdts_pkg::FIELD_W];
  assign high_f = out_tdata[fdts_pkg::OUT_HIGH_LSB +: fdts_pkg::FIELD_W];

  // A result waiting on the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Input is only closed right after a sample transfer closed a window.
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input closed without a sample transfer");

  // Input reopens together with a result being offered.
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_tready) |-> out_tvalid)
    else $error("input reopened without a result");

  // The maximum bounds the mean and both quantiles of the same window.
  a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (max_f >= mean_f) && (max_f >= low_f) && (max_f >= high_f))
    else $error("result field above window maximum");

endmodule

bind flow_delay_tail_stats_top fdts_chk u_fdts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
